// ===== hdl/csht_pkg.sv =====
// ----------------------------------------------------------------------------
// csht_pkg
// types, codes and defaults shared by the chained hash table modules
// ----------------------------------------------------------------------------
package csht_pkg;

  localparam int unsigned LOG2_SLOTS_DEF  = 6;
  localparam int unsigned KEY_WIDTH_DEF   = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOFREE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_bits;
    logic [31:0] key_hash;
    logic [63:0] insert_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [5:0]  slot_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CHK,
    S_IN_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_HOME_RD,
    S_PRED_RD,
    S_PRED_CHK,
    S_MOVE,
    S_WRITE,
    S_CLEAR,
    S_DONE
  } bk_state_e;

endpackage

// ===== hdl/csht_front.sv =====
// ----------------------------------------------------------------------------
// csht_front
// accepts request beats, masks their fields to width and places them in a two-entry queue
// ----------------------------------------------------------------------------
module csht_front import csht_pkg::*; #(
  parameter int unsigned LOG2_SLOTS  = LOG2_SLOTS_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  req_t                   req_i,
  output logic                   busy_o,
  // queue head toward the back part
  output logic                   q_valid_o,
  output logic [1:0]             q_op_o,
  output logic [KEY_WIDTH-1:0]   q_key_o,
  output logic [LOG2_SLOTS-1:0]  q_home_o,
  output logic [VALUE_WIDTH-1:0] q_val_o,
  input  logic                   q_pop_i
);
  localparam int unsigned EW = 2 + KEY_WIDTH + LOG2_SLOTS + VALUE_WIDTH;

  logic [EW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic [EW-1:0] entry;

  // one item in flight at a time, the queue decouples front from back timing
  assign busy_o = (cnt_q != 2'd0) || q_pop_i;
  assign push   = start_i && !busy_o;
  assign entry  = {req_i.opcode, req_i.key_bits[KEY_WIDTH-1:0],
                   req_i.key_hash[LOG2_SLOTS-1:0], req_i.insert_value[VALUE_WIDTH-1:0]};

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= entry;
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign {q_op_o, q_key_o, q_home_o, q_val_o} = mem_q[rp_q];
endmodule

// ===== hdl/csht_back.sv =====
// ----------------------------------------------------------------------------
// csht_back
// sequencer that walks chains, scans for free slots, relocates entries and clears links
// ----------------------------------------------------------------------------
module csht_back import csht_pkg::*; #(
  parameter int unsigned LOG2_SLOTS  = LOG2_SLOTS_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [1:0]             q_op_i,
  input  logic [KEY_WIDTH-1:0]   q_key_i,
  input  logic [LOG2_SLOTS-1:0]  q_home_i,
  input  logic [VALUE_WIDTH-1:0] q_val_i,
  output logic                   q_pop_o,
  output logic                   done_o,
  output rsp_t                   rsp_o
);
  localparam int unsigned SLOTS = 1 << LOG2_SLOTS;
  localparam int unsigned IW    = LOG2_SLOTS;
  localparam int unsigned LW    = LOG2_SLOTS + 1;
  localparam logic [LW-1:0] END_LINK = {LW{1'b1}};
  localparam logic [LW-1:0] SLOTS_L  = LW'(SLOTS);

  // payload memories, one read port each, registered read
  logic [KEY_WIDTH-1:0]   key_mem  [SLOTS];
  logic [VALUE_WIDTH-1:0] val_mem  [SLOTS];
  logic [IW-1:0]          home_mem [SLOTS];
  logic [LW-1:0]          link_mem [SLOTS];
  logic [SLOTS-1:0]       used_q;

  bk_state_e state_q, state_d;

  logic [KEY_WIDTH-1:0]   rkey_q;
  logic [VALUE_WIDTH-1:0] rval_q;
  logic [IW-1:0]          rhome_q;
  logic [LW-1:0]          rlink_q;
  logic [IW-1:0]          raddr;
  logic                   rd_en;

  logic [LW-1:0]  fp_q, cnt_q;
  logic [IW-1:0]  node_q, node_d;
  logic [LW-1:0]  step_q, step_d;
  logic [IW-1:0]  fslot_q;
  logic [IW-1:0]  clr_q;
  logic           init_q;

  // link memory write
  logic           lw_en;
  logic [IW-1:0]  lw_addr;
  logic [LW-1:0]  lw_data;
  // payload write
  logic           pw_en;
  logic [IW-1:0]  pw_addr;
  logic [KEY_WIDTH-1:0]   pw_key;
  logic [VALUE_WIDTH-1:0] pw_val;
  logic [IW-1:0]  pw_home;

  rsp_t rsp_d;
  logic rsp_v;

  logic [IW-1:0] fp_next;
  assign fp_next = IW'(fp_q - LW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (op_e'(q_op_i))
            OP_LOOKUP: state_d = used_q[q_home_i] ? S_LK_RD : S_DONE;
            OP_INSERT: state_d = S_IN_CHK;
            OP_CLEAR:  state_d = S_CLEAR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_LK_RD:  state_d = S_LK_CHK;
      S_LK_CHK: begin
        if (used_q[node_q] && rkey_q == q_key_i) state_d = S_DONE;
        else if (rlink_q >= SLOTS_L || step_q == SLOTS_L - LW'(1)) state_d = S_DONE;
        else state_d = S_LK_RD;
      end
      S_IN_CHK: begin
        if (cnt_q >= SLOTS_L) state_d = S_DONE;
        else if (!used_q[q_home_i]) state_d = S_WRITE;
        else state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (fp_q == '0) state_d = S_DONE;
        else if (!used_q[fp_next]) state_d = S_HOME_RD;
      end
      S_HOME_RD:  state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (rhome_q != q_home_i) state_d = S_PRED_RD;
        else state_d = S_WRITE;
      end
      S_PRED_RD:  state_d = S_PRED_CHK;
      S_PRED_CHK: begin
        if (rlink_q == {1'b0, q_home_i} || rlink_q >= SLOTS_L ||
            step_q == SLOTS_L - LW'(1)) state_d = S_MOVE;
        else state_d = S_PRED_RD;
      end
      S_MOVE:  state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_CLEAR: state_d = (clr_q == IW'(SLOTS - 1)) ? S_DONE : S_CLEAR;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    rd_en = 1'b0;  raddr = node_q;
    node_d = node_q; step_d = step_q;
    lw_en = 1'b0; lw_addr = node_q; lw_data = END_LINK;
    pw_en = 1'b0; pw_addr = q_home_i; pw_key = q_key_i; pw_val = q_val_i;
    pw_home = q_home_i;
    rsp_v = 1'b0; rsp_d = '0;
    case (state_q)
      S_IDLE: begin
        node_d = q_home_i; step_d = '0;
      end
      S_LK_RD: begin
        rd_en = 1'b1; raddr = node_q;
      end
      S_LK_CHK: begin
        node_d = IW'(rlink_q); step_d = step_q + LW'(1);
        if (used_q[node_q] && rkey_q == q_key_i) begin
          rsp_v = 1'b1;
          rsp_d.status = ST_OK;
          rsp_d.read_value = 64'(rval_q);
          rsp_d.slot_index = 6'(node_q);
        end else if (state_d == S_DONE) begin
          rsp_v = 1'b1; rsp_d.status = ST_MISS;
        end
      end
      S_IN_CHK: begin
        if (cnt_q >= SLOTS_L) begin
          rsp_v = 1'b1; rsp_d.status = ST_FULL;
        end else if (!used_q[q_home_i]) begin
          lw_en = 1'b1; lw_addr = q_home_i; lw_data = END_LINK;
        end
      end
      S_SCAN_CHK: begin
        if (fp_q == '0) begin
          rsp_v = 1'b1; rsp_d.status = ST_NOFREE;
        end
      end
      S_HOME_RD: begin
        rd_en = 1'b1; raddr = q_home_i;
      end
      S_SCAN_RD: begin
        node_d = rhome_q; step_d = '0;
      end
      S_PRED_RD: begin
        rd_en = 1'b1; raddr = node_q;
      end
      S_PRED_CHK: begin
        node_d = IW'(rlink_q); step_d = step_q + LW'(1);
        if (rlink_q == {1'b0, q_home_i}) begin
          lw_en = 1'b1; lw_addr = node_q; lw_data = {1'b0, fslot_q};
        end
      end
      S_MOVE: begin
        rd_en = 1'b1; raddr = q_home_i;
      end
      S_WRITE: begin
        pw_en = 1'b1;
        if (used_q[q_home_i] && rhome_q == q_home_i) begin
          // occupant at home: new key goes to the free slot, linked after home
          pw_addr = fslot_q;
          lw_en = 1'b1; lw_addr = q_home_i; lw_data = {1'b0, fslot_q};
        end else if (used_q[q_home_i]) begin
          // occupant moved out: home slot ends its new chain
          lw_en = 1'b1; lw_addr = q_home_i; lw_data = END_LINK;
        end
        rsp_v = 1'b1; rsp_d.status = ST_OK;
        rsp_d.slot_index = 6'(pw_addr);
      end
      S_CLEAR: begin
        lw_en = 1'b1; lw_addr = clr_q; lw_data = END_LINK;
        if (clr_q == IW'(SLOTS - 1) && !init_q) begin
          rsp_v = 1'b1; rsp_d.status = ST_OK;
        end
      end
      S_DONE: begin
        rsp_v = (op_e'(q_op_i) == OP_LOOKUP && !used_q[q_home_i]) ||
                (op_e'(q_op_i) == OP_NOP);
        rsp_d.status = (op_e'(q_op_i) == OP_LOOKUP) ? ST_MISS : ST_OK;
      end
      default: ;
    endcase
  end

  // memory reads and writes
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rkey_q  <= key_mem[raddr];
      rval_q  <= val_mem[raddr];
      rhome_q <= home_mem[raddr];
      rlink_q <= link_mem[raddr];
    end else if (state_q == S_IDLE) begin
      rlink_q <= link_mem[q_home_i];
    end
    if (state_q == S_SCAN_RD && rhome_q != q_home_i) begin
      // relocate occupant from home slot to free slot
      key_mem[fslot_q]  <= rkey_q;
      val_mem[fslot_q]  <= rval_q;
      home_mem[fslot_q] <= rhome_q;
    end else if (pw_en) begin
      key_mem[pw_addr]  <= pw_key;
      val_mem[pw_addr]  <= pw_val;
      home_mem[pw_addr] <= pw_home;
    end
  end

  // link memory: free slot inherits the home link, later writes one at a time
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN_RD) begin
      link_mem[fslot_q] <= rlink_q;
    end else if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= '0;
      fp_q    <= SLOTS_L;
      cnt_q   <= '0;
      node_q  <= '0;
      step_q  <= '0;
      fslot_q <= '0;
      clr_q   <= '0;
      init_q  <= 1'b1;
      done_o  <= 1'b0;
      rsp_o   <= '0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      step_q  <= step_d;
      done_o  <= rsp_v && (q_valid_i);
      if (rsp_v) rsp_o <= rsp_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);
      if (state_q == S_CLEAR && clr_q == IW'(SLOTS - 1)) init_q <= 1'b0;
      if (state_q == S_IDLE && q_valid_i && op_e'(q_op_i) == OP_CLEAR) begin
        used_q <= '0; fp_q <= SLOTS_L; cnt_q <= '0; clr_q <= '0;
      end
      if (state_q == S_SCAN_CHK && fp_q != '0) begin
        fp_q <= fp_q - LW'(1);
        if (!used_q[fp_next]) fslot_q <= fp_next;
      end
      if (state_q == S_MOVE) used_q[fslot_q] <= 1'b1;
      if (state_q == S_WRITE) begin
        used_q[pw_addr] <= 1'b1;
        cnt_q <= cnt_q + LW'(1);
      end
    end
  end

  assign q_pop_o = rsp_v && q_valid_i;
endmodule

// ===== hdl/chained_scatter_hash_table.sv =====
// ----------------------------------------------------------------------------
// chained_scatter_hash_table
// coalesced hash table with descending free pointer and occupant relocation
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the beat is taken on an edge where
// busy is low. One response beat per request appears on rsp_o, flagged by
// done_o for one cycle; the receiver cannot stall it.
// A lookup walks the chain from the home slot node by node. An insert writes
// the home slot when it is free; otherwise the descending free pointer finds
// a free slot, which takes either the new key or an occupant relocated from
// another chain, whose predecessor is then relinked. Clear sweeps the link
// memory, one slot per cycle. The front takes one request at a time: busy
// is high while its queue holds an entry or is popped. busy stays high
// from accept until the cycle of the response strobe, when the next beat
// may be taken. After reset the back part runs the same link-clearing
// sweep; one request queues meanwhile. Keys, values and home tags of
// unused slots are never read.
// ----------------------------------------------------------------------------
module chained_scatter_hash_table import csht_pkg::*; #(
  parameter int unsigned LOG2_SLOTS  = LOG2_SLOTS_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);
  logic                   q_valid, q_pop;
  logic [1:0]             q_op;
  logic [KEY_WIDTH-1:0]   q_key;
  logic [LOG2_SLOTS-1:0]  q_home;
  logic [VALUE_WIDTH-1:0] q_val;

  csht_front #(.LOG2_SLOTS(LOG2_SLOTS), .KEY_WIDTH(KEY_WIDTH),
               .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .q_valid_o(q_valid), .q_op_o(q_op), .q_key_o(q_key), .q_home_o(q_home),
    .q_val_o(q_val), .q_pop_i(q_pop)
  );

  csht_back #(.LOG2_SLOTS(LOG2_SLOTS), .KEY_WIDTH(KEY_WIDTH),
              .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_op_i(q_op), .q_key_i(q_key),
    .q_home_i(q_home), .q_val_i(q_val), .q_pop_o(q_pop), .done_o, .rsp_o
  );
endmodule

// ===== hdl/csht_checker.sv =====
// ----------------------------------------------------------------------------
// csht_props
// port-level checks on request and response beats
// ----------------------------------------------------------------------------
module csht_props import csht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);
  // a request beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // the block is free again when its response beat shows
  a_free_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy during response beat");

  // responses are single-cycle strobes
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("response strobe longer than one cycle");

  // failed responses carry zero data
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.read_value == '0)
    else $error("nonzero value on failed request");
endmodule

bind chained_scatter_hash_table csht_props u_csht_props (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
